/* sv/pncs_pkg.sv */
`default_nettype none

package pncs_pkg;

	// Palette depth used when the top level is not overridden
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	// Beat layout
	localparam int unsigned S_TDATA_W = 32;   // entry_index, red, green, blue
	localparam int unsigned M_TDATA_W = 8;    // nearest_index
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned COLOR_W   = 3 * CHAN_W;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned DIST_W    = 8;
	localparam int unsigned SUM_W     = 10;   // up to 3 * 255
	localparam int unsigned PROD_W    = 20;

	// Divide by 3 as multiply by 683 and shift by 11; exact for sums up to 765
	localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
	localparam int unsigned      DIV3_SHIFT = 11;

	localparam logic [DIST_W-1:0] DIST_LIMIT     = 8'd255;
	localparam logic [IDX_W-1:0]  NO_MATCH_INDEX = 8'd255;

	// tuser codes on the slave side
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic write_en;    // store one palette entry from the accepted beat
		logic start_scan;  // latch query color, rewind scan
		logic issue;       // read next palette entry
		logic flush;       // drop reads still in flight
		logic load_out;    // move final answer into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic issue_last;  // read address is on the last entry
		logic done;        // compare stage hit a zero distance or the last entry
	} dp_status_t;

endpackage

`default_nettype wire

/* sv/palette_nearest_color_search_top.sv */
`default_nettype none

// Nearest palette color search. Keeps a palette of PALETTE_ENTRIES RGB colors
// (8 bits per channel, all black after reset). A slave beat with tuser = 0
// stores red/green/blue at entry_index (indexes at or beyond PALETTE_ENTRIES
// are dropped) and produces no result; it does not stall the input. A beat with
// tuser = 1 scans the palette from entry 0 and returns the index whose
// distance, (|dr| + |dg| + |db|) / 3 truncated, is smallest, lowest index on
// ties. The scan stops early on a zero distance and flags exact_match. If no
// entry gets below 255 the answer is index 255. The scan reads one
// palette entry per cycle from a single-port memory through a two-stage
// distance pipeline. A finished result sits in an output register, so writes
// and the next query can be taken while it waits on m_axis_tready; a new
// result waits for that register to drain.

module palette_nearest_color_search_top #(
	parameter int unsigned PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
	input  wire logic [pncs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] action: 0 write entry, 1 query
	input  wire logic                           s_axis_tuser,

	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [7:0] nearest_index
	output logic      [pncs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [0] exact_match
	output logic                                m_axis_tuser
);
	import pncs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: accepts beats, steps the scan, owns output valid
	pncs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

	// palette memory, distance pipeline, best-so-far tracking, result register
	pncs_dp #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tdata       (s_axis_tdata),
		.cmd           (cmd),
		.status        (status),
		.nearest_index (m_axis_tdata),
		.exact_match   (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* sv/pncs_dp.sv */
`default_nettype none

module pncs_dp #(
	parameter int unsigned PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [pncs_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire pncs_pkg::dp_cmd_t                cmd,
	output pncs_pkg::dp_status_t                  status,
	output logic      [pncs_pkg::IDX_W-1:0]       nearest_index,
	output logic                                  exact_match
);
	import pncs_pkg::*;

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

	function automatic logic [CHAN_W-1:0] absd(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [IDX_W-1:0]   wr_idx;
	logic [COLOR_W-1:0] wr_color;
	logic               wr_hit;

	logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] written_q;

	logic [COLOR_W-1:0] query_q;
	logic [AW-1:0]      rd_addr_q;

	// stage 1: registered memory read
	logic [COLOR_W-1:0] rd_data_s1;
	logic               vld_s1;
	logic               live_s1;
	logic               last_s1;
	logic [AW-1:0]      idx_s1;

	// stage 2: distance
	logic [DIST_W-1:0]  dist_s2;
	logic               live_s2;
	logic               last_s2;
	logic [AW-1:0]      idx_s2;

	// compare stage state
	logic [DIST_W-1:0]  best_q;
	logic [IDX_W-1:0]   answer_q;
	logic               exact_q;

	logic [IDX_W-1:0]   nearest_q;
	logic               exact_out_q;

	logic [COLOR_W-1:0] entry;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;

	assign wr_idx   = s_tdata[IDX_W-1:0];
	assign wr_color = s_tdata[IDX_W +: COLOR_W];
	assign wr_hit   = cmd.write_en && ({1'b0, wr_idx} < (IDX_W+1)'(PALETTE_ENTRIES));

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_idx[AW-1:0]] <= wr_color;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_hit) begin
			written_q[wr_idx[AW-1:0]] <= 1'b1;
		end
	end

	// entries never written read as black
	assign entry = vld_s1 ? rd_data_s1 : '0;
	assign sum = SUM_W'(absd(entry[0 +: CHAN_W], query_q[0 +: CHAN_W]))
	           + SUM_W'(absd(entry[CHAN_W +: CHAN_W], query_q[CHAN_W +: CHAN_W]))
	           + SUM_W'(absd(entry[2*CHAN_W +: CHAN_W], query_q[2*CHAN_W +: CHAN_W]));
	assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			query_q <= wr_color;
		end
		if (cmd.issue) begin
			vld_s1  <= written_q[rd_addr_q];
			idx_s1  <= rd_addr_q;
			last_s1 <= (rd_addr_q == AW'(PALETTE_ENTRIES - 1));
		end
		dist_s2 <= prod[DIV3_SHIFT +: DIST_W];
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			live_s1     <= 1'b0;
			live_s2     <= 1'b0;
			best_q      <= DIST_LIMIT;
			answer_q    <= NO_MATCH_INDEX;
			exact_q     <= 1'b0;
			nearest_q   <= '0;
			exact_out_q <= 1'b0;
		end else begin
			if (cmd.start_scan) begin
				rd_addr_q <= '0;
			end else if (cmd.issue) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end

			live_s1 <= cmd.issue && !cmd.flush;
			live_s2 <= live_s1 && !cmd.flush;

			if (cmd.start_scan) begin
				best_q   <= DIST_LIMIT;
				answer_q <= NO_MATCH_INDEX;
				exact_q  <= 1'b0;
			end else if (live_s2) begin
				// first zero distance ends the scan; otherwise keep strictly smaller
				if (dist_s2 == '0) begin
					answer_q <= IDX_W'(idx_s2);
					exact_q  <= 1'b1;
				end else if (dist_s2 < best_q) begin
					best_q   <= dist_s2;
					answer_q <= IDX_W'(idx_s2);
				end
			end

			if (cmd.load_out) begin
				nearest_q   <= answer_q;
				exact_out_q <= exact_q;
			end
		end
	end

	assign status.issue_last = (rd_addr_q == AW'(PALETTE_ENTRIES - 1));
	assign status.done       = live_s2 && ((dist_s2 == '0) || last_s2);

	assign nearest_index = nearest_q;
	assign exact_match   = exact_out_q;

endmodule

`default_nettype wire

/* sv/pncs_ctrl.sv */
`default_nettype none

module pncs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tuser,
	output logic                      s_axis_tready,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output pncs_pkg::dp_cmd_t         cmd,
	input  wire pncs_pkg::dp_status_t status
);
	import pncs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   issued_all_q;
	logic   m_valid_q;
	logic   accept;
	logic   out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.write_en   = accept && (s_axis_tuser == ACT_WRITE);
		cmd.start_scan = accept && (s_axis_tuser == ACT_QUERY);
		cmd.issue      = (state_q == ST_SCAN) && !issued_all_q && !status.done;
		cmd.flush      = (state_q == ST_SCAN) && status.done;
		cmd.load_out   = (state_q == ST_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issued_all_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_scan) begin
						state_q      <= ST_SCAN;
						issued_all_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cmd.issue && status.issue_last) begin
						issued_all_q <= 1'b1;
					end
					if (status.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/pncs_chk.sv */
`default_nettype none

module pncs_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic [pncs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input wire logic                           s_axis_tuser,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [pncs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                           m_axis_tuser
);
	import pncs_pkg::*;

	// result beat holds until taken
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped before tready");

	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// a query occupies the block for the scan
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY) |=> !s_axis_tready)
		else $error("beat accepted during a scan");

	// palette writes do not stall the input
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_WRITE) |=> s_axis_tready)
		else $error("write stalled the input");

	// a new result only follows a scan
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a scan");

endmodule

bind palette_nearest_color_search_top pncs_chk u_pncs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
